### src/swms_pkg.sv
// ----------------------------------------------------------------------------
// swms_pkg
// shared widths, defaults and codes for the sorted word membership search unit
// ----------------------------------------------------------------------------
package swms_pkg;

    localparam int MODE_W          = 1;
    localparam int ENTRY_INDEX_W   = 12;
    localparam int WORD_W          = 40;
    localparam int VOCAB_W         = 13;

    localparam int DEF_TABLE_DEPTH  = 4096;
    localparam int DEF_WORD_LETTERS = 5;

    localparam logic [MODE_W-1:0] MODE_WRITE  = 1'b0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 1'b1;

endpackage

### src/swms_ram.sv
// ----------------------------------------------------------------------------
// swms_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module swms_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/sorted_word_membership_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_word_membership_search_unit
// binary search membership test over a sorted table of packed words
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  mode, entry_index, word
//  out      out_valid / out_stall found
//  cfg      cfg_we               cfg_wdata (vocab_size)
//
//  a write is taken while idle; a lookup repeats a probe (ram read, then
//  compare) until the word is hit or the interval empties, then goes to done
//  the table ram carries no reset and reads undefined until written
//  reset clears vocab_size, the search state and the output valid flag
//  a finished result waits in the output register while out_stall is high;
//  the next word is taken once the search control is back in idle
// ----------------------------------------------------------------------------
module sorted_word_membership_search_unit #(
    parameter int TABLE_DEPTH  = swms_pkg::DEF_TABLE_DEPTH,
    parameter int WORD_LETTERS = swms_pkg::DEF_WORD_LETTERS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [swms_pkg::VOCAB_W-1:0]       cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [swms_pkg::MODE_W-1:0]        mode,
    input  logic [swms_pkg::ENTRY_INDEX_W-1:0] entry_index,
    input  logic [swms_pkg::WORD_W-1:0]        word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found
);

    import swms_pkg::*;

    localparam int WW    = 8 * WORD_LETTERS;
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [VOCAB_W-1:0] vocab_size_reg;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [WW-1:0]      key_reg, key_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    logic               found_reg, found_next;

    logic [63:0]        word_ext;
    logic [31:0]        idx_ext;
    logic [31:0]        vocab_ext;
    logic [CNT_W-1:0]   n_cnt;
    logic [CNT_W-1:0]   mid_calc;
    logic [CNT_W-1:0]   cmp_lo, cmp_hi;
    logic               accept;
    logic               ram_we;
    logic               ram_re;
    logic [WW-1:0]      ram_rdata;

    assign word_ext  = {24'd0, word};
    assign idx_ext   = {20'd0, entry_index};
    assign vocab_ext = {19'd0, vocab_size_reg};
    assign n_cnt     = (vocab_ext < 32'(TABLE_DEPTH)) ? vocab_ext[CNT_W-1:0] : DEPTH_CNT;
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg - CNT_W'(1)) >> 1);

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign ram_we    = accept && (mode == MODE_WRITE) && (idx_ext < 32'(TABLE_DEPTH));
    assign ram_re    = (state_reg == S_PROBE);

    swms_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (word_ext[WW-1:0]),
        .re    (ram_re),
        .raddr (mid_calc[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        cmp_lo         = lo_reg;
        cmp_hi         = hi_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (mode == MODE_LOOKUP))
                begin
                    key_next  = word_ext[WW-1:0];
                    lo_next   = '0;
                    hi_next   = n_cnt;
                    pend_next = 1'b0;
                    if (n_cnt == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                mid_next   = mid_calc;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (ram_rdata == key_reg)
                begin
                    pend_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    if (ram_rdata < key_reg)
                    begin
                        cmp_lo = mid_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cmp_hi = mid_reg;
                    end
                    lo_next = cmp_lo;
                    hi_next = cmp_hi;
                    if (cmp_lo >= cmp_hi)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vocab_size_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                vocab_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        pend_reg  <= pend_next;
        found_reg <= found_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;

    // search interval stays inside the table and around the probe
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (mid_reg >= lo_reg) && (mid_reg < hi_reg)
                                 && (hi_reg <= DEPTH_CNT))
        else $error("probe index outside search interval");

    a_probe_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |=> (state_reg == S_CMP))
        else $error("ram read not followed by compare");

    a_empty_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_LOOKUP) && (n_cnt == '0))
            |=> (state_reg == S_DONE) && !pend_reg)
        else $error("empty table lookup did not finish as not found");

    a_result_only_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside done state");

endmodule

### bench/tb_sorted_word_membership_search_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_word_membership_search_unit
// self-checking bench for the sorted word membership search unit. a queue of
// pending words feeds a clocked driver; a clocked monitor keeps a shadow copy
// of the word table and vocab_size, predicts every lookup by its own binary
// search and compares each returned found bit against the oldest prediction.
// each phase sets vocab_size while the unit is idle, plans a sorted (or
// deliberately unsorted) table layout and writes every entry that the
// planned lookups will probe, so no search ever touches an unwritten entry.
// ----------------------------------------------------------------------------
module tb_sorted_word_membership_search_unit;

    import swms_pkg::*;

    localparam int RUN_LIMIT_NS    = 10_000_000;
    localparam int DRAIN_LIMIT     = 200_000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PRESSURE_CYCLES = 400;
    localparam int LETTER_BITS     = 8 * DEF_WORD_LETTERS;
    localparam logic [WORD_W-1:0] LETTER_MASK = {WORD_W{1'b1}} >> (WORD_W - LETTER_BITS);
    localparam logic [WORD_W-1:0] ALL_ONES    = {WORD_W{1'b1}};

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic [ENTRY_INDEX_W-1:0] idx;
        logic [WORD_W-1:0]        w;
    } table_op_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [VOCAB_W-1:0]       cfg_wdata;
    logic                     in_valid;
    logic                     in_stall;
    logic [MODE_W-1:0]        mode;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [WORD_W-1:0]        word;
    logic                     out_valid;
    logic                     out_stall;
    logic                     found;

    // shadow state of the unit
    logic [WORD_W-1:0]  table_copy [DEF_TABLE_DEPTH];
    logic [VOCAB_W-1:0] vocab_copy;

    // planned layout for the current phase and which entries hold it
    logic [WORD_W-1:0]  layout [DEF_TABLE_DEPTH];
    bit                 fresh  [DEF_TABLE_DEPTH];

    table_op_t pending_ops [$];
    logic      expected_found [$];

    bit        word_taken;
    bit        no_idle;
    bit        pressure_go;
    bit        hold_on;
    int        in_gap;
    int        stall_left;
    int        errors;
    int        items_queued;
    int        writes_done;
    int        results_checked;
    int        hits_seen;
    int        held_cycles;
    int        settings_done;
    table_op_t drive_op;
    logic      want_found;

    sorted_word_membership_search_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .entry_index (entry_index),
        .word        (word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 20)
        begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[WORD_W-1:0];
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int searched_entries(input logic [VOCAB_W-1:0] vocab);
        return (vocab > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : int'(vocab);
    endfunction

    // half-open-interval binary search on the shadow table
    function automatic logic word_in_table(input logic [WORD_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = searched_entries(vocab_copy);
        while (lo < hi)
        begin
            mid = lo + (hi - 1 - lo) / 2;
            if (table_copy[mid] == key)
                return 1'b1;
            else if (table_copy[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return 1'b0;
    endfunction

    task automatic queue_op(input logic [MODE_W-1:0] m, input int idx,
                            input logic [WORD_W-1:0] w);
        table_op_t op;
        op.mode = m;
        op.idx  = idx[ENTRY_INDEX_W-1:0];
        op.w    = w;
        pending_ops.push_back(op);
        items_queued++;
    endtask

    task automatic queue_lookup(input logic [WORD_W-1:0] w);
        queue_op(MODE_LOOKUP, $urandom_range(0, DEF_TABLE_DEPTH - 1), w);
    endtask

    task automatic wait_idle();
        int spins;
        spins = 0;
        while ((pending_ops.size() != 0 || in_valid || expected_found.size() != 0)
               && spins < DRAIN_LIMIT)
        begin
            @(negedge clk);
            spins++;
        end
        if (spins >= DRAIN_LIMIT)
            report_mismatch($sformatf("%0d results never arrived", expected_found.size()));
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_vocab(input int v);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= VOCAB_W'(v);
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_done++;
    endtask

    // writes the planned value of every entry that the search for key will probe
    task automatic queue_planned_lookup(input int n, input logic [WORD_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n;
        while (lo < hi)
        begin
            mid = lo + (hi - 1 - lo) / 2;
            if (!fresh[mid])
            begin
                queue_op(MODE_WRITE, mid, layout[mid]);
                fresh[mid] = 1'b1;
            end
            if (layout[mid] == key)
                hi = lo;
            else if (layout[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        queue_lookup(key);
    endtask

    task automatic random_phase(input int vocab, input bit sorted,
                                input int budget, input bit quiet);
        int          n;
        int          start;
        int          i;
        logic [63:0] span;
        logic [63:0] step;
        logic [WORD_W-1:0] key;
        set_vocab(vocab);
        no_idle = quiet;
        n = searched_entries(VOCAB_W'(vocab));
        for (i = 0; i < DEF_TABLE_DEPTH; i++)
            fresh[i] = 1'b0;
        if (n > 0)
        begin
            span = 64'(ALL_ONES) / (n + 1);
            layout[0] = sorted ? WORD_W'(64'(rand_word()) % span) : rand_word();
            for (i = 1; i < n; i++)
            begin
                step = 64'(rand_word()) % span + 1;
                layout[i] = sorted ? layout[i-1] + WORD_W'(step) : rand_word();
            end
            if (sorted && $urandom_range(0, 1) == 1)
            begin
                layout[0]   = '0;
                layout[n-1] = ALL_ONES;
            end
        end
        start = items_queued;
        while (items_queued - start < budget)
        begin
            if (n == 0 || $urandom_range(0, 99) < 20)
            begin
                if (n == DEF_TABLE_DEPTH || (n > 0 && $urandom_range(0, 1) == 1))
                begin
                    i = $urandom_range(0, n - 1);
                    queue_op(MODE_WRITE, i, layout[i]);
                    fresh[i] = 1'b1;
                end
                else
                begin
                    queue_op(MODE_WRITE, $urandom_range(n, DEF_TABLE_DEPTH - 1), rand_word());
                end
                if (n == 0)
                    queue_lookup($urandom_range(0, 1) ? rand_word() : '0);
            end
            else
            begin
                i = $urandom_range(0, n - 1);
                case ($urandom_range(0, 5))
                    0, 1:    key = layout[i];
                    2:       key = layout[i] + 1'b1;
                    3:       key = layout[i] - 1'b1;
                    4:       key = rand_word();
                    default: key = $urandom_range(0, 1) ? ALL_ONES : '0;
                endcase
                queue_planned_lookup(n, key);
            end
        end
    endtask

    // monitor and predictor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                vocab_copy = cfg_wdata;
            if (out_valid && !out_stall)
            begin
                if (expected_found.size() == 0)
                begin
                    report_mismatch("found returned with no lookup pending");
                end
                else
                begin
                    want_found = expected_found.pop_front();
                    results_checked++;
                    if (want_found)
                        hits_seen++;
                    if (found !== want_found)
                        report_mismatch($sformatf("found %b, predicted %b", found, want_found));
                end
            end
            word_taken = in_valid && !in_stall;
            if (in_valid && in_stall)
                held_cycles++;
            if (word_taken)
            begin
                if (mode == MODE_WRITE)
                begin
                    if (entry_index < DEF_TABLE_DEPTH)
                        table_copy[entry_index] = word & LETTER_MASK;
                    writes_done++;
                end
                else
                begin
                    expected_found.push_back(word_in_table(word & LETTER_MASK));
                end
            end
        end
    end

    // driver for both channels
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || word_taken)
            begin
                if (in_gap > 0 || pending_ops.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap--;
                end
                else
                begin
                    drive_op = pending_ops.pop_front();
                    in_valid    <= 1'b1;
                    mode        <= drive_op.mode;
                    entry_index <= drive_op.idx;
                    word        <= drive_op.w;
                    in_gap = no_idle ? 0 : idle_len();
                end
            end
            if (hold_on)
            begin
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // long receiver hold-off so the unit backs up into its input
    initial
    begin
        hold_on = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("sorted_word_membership_search_unit verification failed");
        $finish;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        mode        = MODE_WRITE;
        entry_index = '0;
        word        = '0;
        out_stall   = 1'b0;
        vocab_copy  = '0;
        no_idle     = 1'b0;
        pressure_go = 1'b0;
        word_taken  = 1'b0;
        for (int i = 0; i < DEF_TABLE_DEPTH; i++)
            table_copy[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table
        set_vocab(0);
        queue_op(MODE_WRITE, DEF_TABLE_DEPTH - 1, ALL_ONES);
        queue_op(MODE_LOOKUP, DEF_TABLE_DEPTH - 1, ALL_ONES);
        queue_op(MODE_LOOKUP, 0, '0);

        // single word: hit, below (left move at midpoint zero), above
        set_vocab(1);
        queue_op(MODE_WRITE, 0, 40'h6d_61_70_6c_65);
        queue_lookup(40'h6d_61_70_6c_65);
        queue_lookup(40'h61_70_70_6c_65);
        queue_lookup(40'h7a_65_62_72_61);
        queue_lookup('0);
        queue_lookup(ALL_ONES);

        // three words spanning the extremes
        set_vocab(3);
        queue_op(MODE_WRITE, 0, '0);
        queue_op(MODE_WRITE, 1, 40'h6d_61_70_6c_65);
        queue_op(MODE_WRITE, 2, ALL_ONES);
        queue_lookup('0);
        queue_lookup(ALL_ONES);
        queue_lookup(40'h6d_61_70_6c_65);
        queue_lookup(40'h6d_61_70_6c_66);
        queue_lookup(40'h6d_61_70_6c_64);
        queue_lookup(40'h00_00_00_00_01);

        random_phase(1, 1'b1, 120, 1'b0);
        random_phase(2, 1'b1, 120, 1'b1);
        random_phase(7, 1'b1, 150, 1'b0);
        pressure_go = 1'b1;
        random_phase(100, 1'b1, 180, 1'b0);
        random_phase(DEF_TABLE_DEPTH, 1'b1, 400, 1'b0);
        random_phase(int'({VOCAB_W{1'b1}}), 1'b1, 250, 1'b1);
        random_phase(DEF_TABLE_DEPTH - 1, 1'b1, 150, 1'b0);
        random_phase(500, 1'b0, 150, 1'b0);
        random_phase(13, 1'b0, 120, 1'b0);
        random_phase($urandom_range(1, DEF_TABLE_DEPTH), 1'b1, 150, 1'b0);
        random_phase(0, 1'b1, 60, 1'b0);
        wait_idle();

        $display("run covered %0d table writes and %0d lookups (%0d found)",
                 writes_done, results_checked, hits_seen);
        $display("over %0d vocab_size settings; input held back for %0d cycles, %0d mismatches",
                 settings_done, held_cycles, errors);
        if (errors == 0)
            $display("sorted_word_membership_search_unit verification clean");
        else
            $display("sorted_word_membership_search_unit verification failed");
        $finish;
    end

endmodule
